>>> hw/rtl/cccr_pkg.sv
// ----------------------------------------------------------------------------
// cccr_pkg
// Shared types, codes and constants of the cluster chain reader.
// ----------------------------------------------------------------------------
package cccr_pkg;

    localparam int unsigned MAX_CLUSTER_SHIFT = 5;
    localparam int unsigned BLOCK_BYTES       = 512;
    localparam int unsigned BLOCK_BITS        = $clog2(BLOCK_BYTES);
    localparam int unsigned FAT_WORDS         = BLOCK_BYTES / 4;
    localparam int unsigned WORD_BITS         = $clog2(FAT_WORDS);
    localparam int unsigned CLUSTER_W         = 28;
    localparam int unsigned SHIFT_W           = 3;
    localparam int unsigned CFG_IDX_W         = 3;
    localparam int unsigned CMD_QUEUE_DEPTH   = 2;

    localparam logic [CLUSTER_W-1:0] CHAIN_END = 28'hFFFFFF7;

    typedef logic [1:0] t_action;
    localparam t_action ACT_FAT_FETCH = 2'd0;
    localparam t_action ACT_SEGMENT   = 2'd1;
    localparam t_action ACT_FINISH    = 2'd2;

    typedef logic [1:0] t_cmd_kind;
    localparam t_cmd_kind CMD_EOF  = 2'd0;
    localparam t_cmd_kind CMD_READ = 2'd1;
    localparam t_cmd_kind CMD_FAT  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_FAT_BASE      = 3'd0;
    localparam t_reg_idx REG_DATA_BASE     = 3'd1;
    localparam t_reg_idx REG_CLUSTER_SHIFT = 3'd2;
    localparam t_reg_idx REG_START_CLUSTER = 3'd3;
    localparam t_reg_idx REG_FILE_LENGTH   = 3'd4;

    typedef struct packed {
        logic [31:0]          fat_base;
        logic [31:0]          data_base;
        logic [SHIFT_W-1:0]   cluster_shift;
        logic [CLUSTER_W-1:0] start_cluster;
        logic [31:0]          file_length;
    } t_cfg;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [31:0]          offset;
        logic [31:0]          length;
        logic [CLUSTER_W-1:0] entry;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

>>> hw/rtl/cccr_if.sv
// ----------------------------------------------------------------------------
// cccr_if
// Valid/ready channels of the cluster chain reader: request, result, config.
// ----------------------------------------------------------------------------
interface cccr_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [31:0] read_offset;
    logic [31:0] read_length;
    logic [31:0] fat_entry;

    modport source (output valid, req_type, read_offset, read_length, fat_entry,
                    input ready);
    modport sink   (input valid, req_type, read_offset, read_length, fat_entry,
                    output ready);
endinterface

interface cccr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] block_address;
    logic [6:0]  word_index;
    logic [8:0]  byte_start;
    logic [9:0]  byte_count;
    logic [31:0] bytes_done;
    logic        last;

    modport source (output valid, action, block_address, word_index, byte_start,
                    byte_count, bytes_done, last, input ready);
    modport sink   (input valid, action, block_address, word_index, byte_start,
                    byte_count, bytes_done, last, output ready);
endinterface

interface cccr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/cccr_front.sv
// ----------------------------------------------------------------------------
// cccr_front
// Configuration registers, request intake, clipping and classification.
// ----------------------------------------------------------------------------
module cccr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cccr_req_if.sink       i_req,
    cccr_cfg_if.sink       i_cfg,
    input  cccr_pkg::t_q_stat i_q_stat,
    output logic           o_push,
    output cccr_pkg::t_cmd o_cmd,
    output cccr_pkg::t_cfg o_cfg,
    output logic           o_flush
);
    import cccr_pkg::*;

    t_cfg        r_cfg;
    logic        cfg_fire;
    logic        past_end;
    logic [32:0] end_sum;

    assign i_cfg.ready = 1'b1;
    assign cfg_fire    = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;
    assign o_flush     = cfg_fire && (i_cfg.index == REG_CLUSTER_SHIFT ||
                                      i_cfg.index == REG_START_CLUSTER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fat_base      <= '0;
            r_cfg.data_base     <= '0;
            r_cfg.cluster_shift <= '0;
            r_cfg.start_cluster <= CLUSTER_W'(2);
            r_cfg.file_length   <= '0;
        end else if (cfg_fire) begin
            unique case (i_cfg.index)
                REG_FAT_BASE:      r_cfg.fat_base      <= i_cfg.data;
                REG_DATA_BASE:     r_cfg.data_base     <= i_cfg.data;
                REG_CLUSTER_SHIFT: r_cfg.cluster_shift <= i_cfg.data[SHIFT_W-1:0];
                REG_START_CLUSTER: r_cfg.start_cluster <= i_cfg.data[CLUSTER_W-1:0];
                REG_FILE_LENGTH:   r_cfg.file_length   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_req.ready = !i_q_stat.full;
    assign o_push      = i_req.valid && i_req.ready;

    assign past_end = i_req.read_offset >= r_cfg.file_length;
    assign end_sum  = {1'b0, i_req.read_offset} + {1'b0, i_req.read_length};

    always_comb begin
        o_cmd.offset = i_req.read_offset;
        o_cmd.entry  = i_req.fat_entry[CLUSTER_W-1:0];
        o_cmd.length = i_req.read_length;
        if (end_sum > {1'b0, r_cfg.file_length}) begin
            o_cmd.length = r_cfg.file_length - i_req.read_offset;
        end
        if (i_req.req_type) begin
            o_cmd.kind = CMD_FAT;
        end else if (past_end) begin
            o_cmd.kind = CMD_EOF;
        end else begin
            o_cmd.kind = CMD_READ;
        end
    end

endmodule

>>> hw/rtl/cccr_queue.sv
// ----------------------------------------------------------------------------
// cccr_queue
// Short command queue between intake and walker.
// ----------------------------------------------------------------------------
module cccr_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cccr_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output cccr_pkg::t_cmd    o_cmd,
    output cccr_pkg::t_q_stat o_stat
);
    import cccr_pkg::*;

    localparam int unsigned PTR_W = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CMD_QUEUE_DEPTH + 1);

    t_cmd             r_mem [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(CMD_QUEUE_DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == CNT_W'(CMD_QUEUE_DEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

>>> hw/rtl/cccr_back.sv
// ----------------------------------------------------------------------------
// cccr_back
// Cursor keeper and chain walker; emits one result per cycle while the result channel is ready.
// ----------------------------------------------------------------------------
module cccr_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cccr_pkg::t_cfg    i_cfg,
    input  logic              i_flush,
    input  cccr_pkg::t_cmd    i_cmd,
    input  cccr_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    cccr_res_if.source        o_res
);
    import cccr_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_RUN  = 2'd2;

    logic [1:0]           r_state,    n_state;
    logic [CLUSTER_W-1:0] r_cur_clu,  n_cur_clu;
    logic [31:0]          r_cur_off,  n_cur_off;
    logic                 r_cur_vld,  n_cur_vld;
    logic [31:0]          r_pend_off, n_pend_off;
    logic [31:0]          r_pend_rem, n_pend_rem;
    logic [31:0]          r_done,     n_done;
    logic                 r_await,    n_await;
    logic [31:0]          r_clu_base, n_clu_base;
    logic [32:0]          r_cur_end,  n_cur_end;

    logic                 r_out_vld,  n_out_vld;
    t_action              r_out_act,  n_out_act;
    logic [31:0]          r_out_blk,  n_out_blk;
    logic [WORD_BITS-1:0] r_out_word, n_out_word;
    logic [8:0]           r_out_bst,  n_out_bst;
    logic [9:0]           r_out_bcnt, n_out_bcnt;
    logic [31:0]          r_out_done, n_out_done;
    logic                 r_out_last, n_out_last;

    logic                 slot;
    logic [SHIFT_W-1:0]   sh;
    logic [32:0]          bpc;
    logic [32:0]          clu_sh;
    logic [31:0]          rel;
    logic [BLOCK_BITS-1:0] bstart;
    logic [9:0]           room;
    logic [9:0]           cnt;
    logic                 advance;
    logic                 chain_end;

    assign slot = !r_out_vld || o_res.ready;
    assign sh   = (i_cfg.cluster_shift > SHIFT_W'(MAX_CLUSTER_SHIFT)) ?
                  SHIFT_W'(MAX_CLUSTER_SHIFT) : i_cfg.cluster_shift;
    assign bpc    = 33'(BLOCK_BYTES) << sh;
    assign clu_sh = {5'b0, r_cur_clu} << sh;
    assign rel    = r_pend_off - r_cur_off;
    assign bstart = rel[BLOCK_BITS-1:0];
    assign room   = 10'(BLOCK_BYTES) - {1'b0, bstart};
    assign cnt    = (r_pend_rem < {22'b0, room}) ? r_pend_rem[9:0] : room;
    assign advance   = ({1'b0, r_pend_off} >= r_cur_end) && (r_cur_clu < CHAIN_END);
    assign chain_end = r_cur_clu >= CHAIN_END;

    assign o_res.valid         = r_out_vld;
    assign o_res.action        = r_out_act;
    assign o_res.block_address = r_out_blk;
    assign o_res.word_index    = r_out_word;
    assign o_res.byte_start    = r_out_bst;
    assign o_res.byte_count    = r_out_bcnt;
    assign o_res.bytes_done    = r_out_done;
    assign o_res.last          = r_out_last;

    always_comb begin
        n_state    = r_state;
        n_cur_clu  = r_cur_clu;
        n_cur_off  = r_cur_off;
        n_cur_vld  = r_cur_vld;
        n_pend_off = r_pend_off;
        n_pend_rem = r_pend_rem;
        n_done     = r_done;
        n_await    = r_await;
        n_clu_base = r_clu_base;
        n_cur_end  = r_cur_end;
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out_act  = r_out_act;
        n_out_blk  = r_out_blk;
        n_out_word = r_out_word;
        n_out_bst  = r_out_bst;
        n_out_bcnt = r_out_bcnt;
        n_out_done = r_out_done;
        n_out_last = r_out_last;
        o_pop      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_q_stat.empty && slot) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_EOF: begin
                            n_await    = 1'b0;
                            n_pend_rem = '0;
                            n_done     = '0;
                            n_out_vld  = 1'b1;
                            n_out_act  = ACT_FINISH;
                            n_out_blk  = '0;
                            n_out_word = '0;
                            n_out_bst  = '0;
                            n_out_bcnt = '0;
                            n_out_done = '0;
                            n_out_last = 1'b1;
                        end
                        CMD_READ: begin
                            n_await = 1'b0;
                            n_done  = '0;
                            if (!r_cur_vld || i_cmd.offset < r_cur_off) begin
                                n_cur_clu = i_cfg.start_cluster;
                                n_cur_off = '0;
                                n_cur_vld = 1'b1;
                            end
                            n_pend_off = i_cmd.offset;
                            n_pend_rem = i_cmd.length;
                            n_state    = S_PREP;
                        end
                        CMD_FAT: begin
                            if (r_await) begin
                                n_await   = 1'b0;
                                n_cur_clu = i_cmd.entry;
                                n_state   = S_PREP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_PREP: begin
                n_clu_base = i_cfg.data_base + clu_sh[31:0];
                n_cur_end  = {1'b0, r_cur_off} + bpc;
                n_state    = S_RUN;
            end
            S_RUN: begin
                if (slot) begin
                    n_out_vld  = 1'b1;
                    n_out_blk  = '0;
                    n_out_word = '0;
                    n_out_bst  = '0;
                    n_out_bcnt = '0;
                    n_out_done = '0;
                    n_out_last = 1'b1;
                    if (r_pend_rem != '0 && advance) begin
                        n_cur_off  = r_cur_end[31:0];
                        n_await    = 1'b1;
                        n_out_act  = ACT_FAT_FETCH;
                        n_out_blk  = i_cfg.fat_base + 32'(r_cur_clu >> WORD_BITS);
                        n_out_word = r_cur_clu[WORD_BITS-1:0];
                        n_state    = S_IDLE;
                    end else if (r_pend_rem == '0 || chain_end) begin
                        n_pend_rem = '0;
                        n_out_act  = ACT_FINISH;
                        n_out_done = r_done;
                        n_state    = S_IDLE;
                    end else begin
                        n_pend_rem = r_pend_rem - {22'b0, cnt};
                        n_pend_off = r_pend_off + {22'b0, cnt};
                        n_done     = r_done + {22'b0, cnt};
                        n_out_act  = ACT_SEGMENT;
                        n_out_blk  = r_clu_base + (rel >> BLOCK_BITS);
                        n_out_bst  = bstart;
                        n_out_bcnt = cnt;
                        n_out_last = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_flush) begin
            n_cur_vld  = 1'b0;
            n_await    = 1'b0;
            n_pend_rem = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_clu  <= '0;
            r_cur_off  <= '0;
            r_cur_vld  <= 1'b0;
            r_pend_off <= '0;
            r_pend_rem <= '0;
            r_done     <= '0;
            r_await    <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_clu  <= n_cur_clu;
            r_cur_off  <= n_cur_off;
            r_cur_vld  <= n_cur_vld;
            r_pend_off <= n_pend_off;
            r_pend_rem <= n_pend_rem;
            r_done     <= n_done;
            r_await    <= n_await;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_clu_base <= n_clu_base;
        r_cur_end  <= n_cur_end;
        r_out_act  <= n_out_act;
        r_out_blk  <= n_out_blk;
        r_out_word <= n_out_word;
        r_out_bst  <= n_out_bst;
        r_out_bcnt <= n_out_bcnt;
        r_out_done <= n_out_done;
        r_out_last <= n_out_last;
    end

endmodule

>>> hw/rtl/fat32_cluster_chain_reader_unit.sv
// ----------------------------------------------------------------------------
// fat32_cluster_chain_reader_unit
// Turns file byte reads into FAT word fetches and data segments of up to 512 bytes.
// ----------------------------------------------------------------------------
// A read request or FAT reply passes the intake and a two-entry command queue,
// then the walker takes it: it picks the item up in the idle state, sets up the
// cluster base in the prepare state, then emits one result per cycle while the
// result channel is ready (one data segment per block of the current cluster, up
// to 32, followed by a FAT fetch or the finished result). The walker takes no
// new item until it is back in idle. A FAT fetch result ends a request; the walk
// resumes when the FAT reply arrives as an input item.
// Configuration writes are taken every cycle and must be made while idle.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_reader_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cccr_req_if.sink   i_req,
    cccr_res_if.source o_res,
    cccr_cfg_if.sink   i_cfg
);
    import cccr_pkg::*;

    t_cfg    cfg;
    t_cmd    push_cmd;
    t_cmd    head_cmd;
    t_q_stat q_stat;
    logic    push;
    logic    pop;
    logic    flush;

    cccr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (push_cmd),
        .o_cfg    (cfg),
        .o_flush  (flush)
    );

    cccr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    cccr_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_flush  (flush),
        .i_cmd    (head_cmd),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

endmodule

>>> hw/rtl/cccr_checker.sv
// ----------------------------------------------------------------------------
// cccr_checker
// Result channel checks of the cluster chain reader, bound to the top level.
// ----------------------------------------------------------------------------
module cccr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [1:0]  i_action,
    input logic [31:0] i_block_address,
    input logic [6:0]  i_word_index,
    input logic [8:0]  i_byte_start,
    input logic [9:0]  i_byte_count,
    input logic [31:0] i_bytes_done,
    input logic        i_last
);
    import cccr_pkg::*;

    logic [10:0] seg_end;
    assign seg_end = {2'b0, i_byte_start} + {1'b0, i_byte_count};

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_action) &&
        $stable(i_block_address) && $stable(i_byte_count) && $stable(i_last))
        else $error("result changed while stalled");

    a_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action == ACT_SEGMENT |->
        !i_last && i_byte_count != 10'd0 && seg_end <= 11'(BLOCK_BYTES) &&
        i_bytes_done == 32'd0)
        else $error("malformed data segment");

    a_closing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action != ACT_SEGMENT |->
        i_last && i_byte_count == 10'd0 && i_byte_start == 9'd0 &&
        (i_action == ACT_FAT_FETCH || i_action == ACT_FINISH))
        else $error("closing result malformed");

    a_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_action == ACT_FINISH |->
        i_block_address == 32'd0 && i_word_index == 7'd0)
        else $error("finished result carries an address");

endmodule

bind fat32_cluster_chain_reader_unit cccr_checker u_cccr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_action        (o_res.action),
    .i_block_address (o_res.block_address),
    .i_word_index    (o_res.word_index),
    .i_byte_start    (o_res.byte_start),
    .i_byte_count    (o_res.byte_count),
    .i_bytes_done    (o_res.bytes_done),
    .i_last          (o_res.last)
);
